[rtl/nad_pkg.sv]
package nad_pkg;

   localparam int POS_W  = 6;   // position / slot field width
   localparam int PTR_W  = 7;   // scan pointer, holds the table depth itself
   localparam int SPAN_W = 12;  // first in [11:6], last in [5:0]

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic REG_PARSING_SOURCE = 1'b0;
   localparam logic REG_POSITION_COUNT = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [POS_W-1:0]  slot;
      logic              entry_valid;
      logic [POS_W-1:0]  span_first;
      logic [POS_W-1:0]  span_last;
      logic [POS_W-1:0]  src_pos;
      logic [POS_W-1:0]  trg_pos;
      logic [63:0]       coverage;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]  prev_slot;
      logic [POS_W-1:0]  prev_penalty;
      logic [POS_W-1:0]  next_slot;
      logic [POS_W-1:0]  next_penalty;
      logic [POS_W:0]    total_distortion;
   } rsp_type;

   typedef struct packed {
      logic              parsing_source;
      logic [PTR_W-1:0]  position_count;
   } cfg_type;

endpackage

[rtl/nearest_anchor_distortion.sv]
// channel | ports                                          | beat taken when
// --------+------------------------------------------------+------------------------------
// request | start, busy, req_payload                       | start && !busy at rising edge
// result  | rsp_valid, rsp_payload                         | rsp_valid, one cycle, no stall
// config  | psel penable pwrite paddr pwdata prdata pready | psel && penable && pwrite
//
// A load beat writes the table as it is taken and never raises busy.
// A query beat walks the table one slot per cycle through a single scan
// pointer: down from anchor - 1 until a valid entry or slot 0, a charge
// state for a found entry, then up from anchor + 1 until a valid entry or
// the clamped position_count, a charge state for a found entry, and a
// total state. Anchor zero goes straight to the total state. The result
// strobe is high in the first cycle that busy is low; a new beat may be
// taken in that same cycle. The receiver cannot stall results.
// Synchronous reset clears the valid bits at once and sets the registers to
// parsing_source = 1, position_count = 64. The span store is not cleared.
module nearest_anchor_distortion #(
   parameter int MAX_POSITIONS = 64
) (
   input  logic              clock,
   input  logic              reset,
   // request
   input  logic              start,
   output logic              busy,
   input  nad_pkg::req_type  req_payload,
   // result
   output logic              rsp_valid,
   output nad_pkg::rsp_type  rsp_payload,
   // configuration
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import nad_pkg::*;

   localparam int AW = $clog2(MAX_POSITIONS);
   localparam logic [PTR_W-1:0] DEPTH = PTR_W'(MAX_POSITIONS);

   cfg_type          cfg_ff, cfg_in;
   logic             cfg_wr;
   logic             accept;
   logic             load_wr;
   logic             query;
   logic [PTR_W-1:0] scan_ptr;
   logic             scan_valid;
   logic [SPAN_W-1:0] span_rd;

   // ---------------- configuration registers ----------------
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         unique case (paddr[2])
            REG_PARSING_SOURCE: cfg_in.parsing_source = pwdata[0];
            REG_POSITION_COUNT: cfg_in.position_count = pwdata[PTR_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_PARSING_SOURCE: prdata = {31'd0, cfg_ff.parsing_source};
         REG_POSITION_COUNT: prdata = {{(32-PTR_W){1'b0}}, cfg_ff.position_count};
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.parsing_source <= 1'b1;
         cfg_ff.position_count <= PTR_W'(64);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- request decode ----------------
   assign accept  = start && !busy;
   // loads to slots past the table depth are dropped
   assign load_wr = accept && (req_payload.kind == KIND_LOAD)
                    && ({1'b0, req_payload.slot} < DEPTH);
   assign query   = accept && (req_payload.kind == KIND_QUERY);

   nad_table #(
      .MAX_POSITIONS (MAX_POSITIONS),
      .AW            (AW)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (load_wr),
      .wr_addr    (req_payload.slot[AW-1:0]),
      .wr_valid   (req_payload.entry_valid),
      .wr_span    ({req_payload.span_first, req_payload.span_last}),
      .scan_ptr   (scan_ptr),
      .scan_valid (scan_valid),
      .span_rd    (span_rd)
   );

   // scan sequencer with shared add/subtract unit
   nad_seq #(
      .MAX_POSITIONS (MAX_POSITIONS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .query      (query),
      .req        (req_payload),
      .cfg        (cfg_ff),
      .scan_valid (scan_valid),
      .span_rd    (span_rd),
      .scan_ptr   (scan_ptr),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp_payload)
   );

endmodule

[rtl/nad_table.sv]
module nad_table #(
   parameter int MAX_POSITIONS = 64,
   parameter int AW = $clog2(MAX_POSITIONS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic                         wr_valid,
   input  logic [nad_pkg::SPAN_W-1:0]   wr_span,
   input  logic [nad_pkg::PTR_W-1:0]    scan_ptr,
   output logic                         scan_valid,
   output logic [nad_pkg::SPAN_W-1:0]   span_rd
);
   import nad_pkg::*;

   localparam logic [PTR_W-1:0] DEPTH = PTR_W'(MAX_POSITIONS);

   logic [MAX_POSITIONS-1:0] vld_ff;
   logic [MAX_POSITIONS-1:0] vld_in;
   logic [SPAN_W-1:0]        span_mem [MAX_POSITIONS];
   logic [SPAN_W-1:0]        span_ff;
   logic                     in_range;

   assign in_range   = scan_ptr < DEPTH;
   assign scan_valid = in_range && vld_ff[scan_ptr[AW-1:0]];
   assign span_rd    = span_ff;

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = wr_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // span store: one write port, registered read at the scan pointer
   always_ff @(posedge clock) begin
      if (wr_en) begin
         span_mem[wr_addr] <= wr_span;
      end
      span_ff <= span_mem[scan_ptr[AW-1:0]];
   end

endmodule

[rtl/nad_seq.sv]
module nad_seq #(
   parameter int MAX_POSITIONS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       query,
   input  nad_pkg::req_type           req,
   input  nad_pkg::cfg_type           cfg,
   input  logic                       scan_valid,
   input  logic [nad_pkg::SPAN_W-1:0] span_rd,
   output logic [nad_pkg::PTR_W-1:0]  scan_ptr,
   output logic                       busy,
   output logic                       rsp_valid,
   output nad_pkg::rsp_type           rsp
);
   import nad_pkg::*;

   localparam logic [PTR_W-1:0] DEPTH = PTR_W'(MAX_POSITIONS);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_DOWN  = 6'b000010,
      S_PCALC = 6'b000100,
      S_UP    = 6'b001000,
      S_NCALC = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [POS_W-1:0]  anchor_ff, anchor_in;
   logic [POS_W-1:0]  other_ff, other_in;
   logic [63:0]       cov_ff, cov_in;
   logic [PTR_W-1:0]  limit_ff, limit_in;
   logic [POS_W-1:0]  pslot_ff, pslot_in;
   logic [POS_W-1:0]  ppen_ff, ppen_in;
   logic [POS_W-1:0]  nslot_ff, nslot_in;
   logic [POS_W-1:0]  npen_ff, npen_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // shared add/subtract unit
   logic [POS_W-1:0]  alu_a, alu_b;
   logic              alu_sub;
   logic [POS_W+1:0]  alu_res;
   logic              alu_pos;
   logic [POS_W-1:0]  anchor_sel;

   assign alu_res = alu_sub ? ({2'b00, alu_a} - {2'b00, alu_b})
                            : ({2'b00, alu_a} + {2'b00, alu_b});
   assign alu_pos = !alu_res[POS_W+1] && (alu_res != '0);

   assign anchor_sel = cfg.parsing_source ? req.src_pos : req.trg_pos;

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      anchor_in    = anchor_ff;
      other_in     = other_ff;
      cov_in       = cov_ff;
      limit_in     = limit_ff;
      pslot_in     = pslot_ff;
      ppen_in      = ppen_ff;
      nslot_in     = nslot_ff;
      npen_in      = npen_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      alu_a        = span_rd[SPAN_W-1:POS_W];
      alu_b        = other_ff;
      alu_sub      = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (query) begin
               anchor_in = anchor_sel;
               other_in  = cfg.parsing_source ? req.trg_pos : req.src_pos;
               cov_in    = req.coverage;
               limit_in  = (cfg.position_count > DEPTH) ? DEPTH : cfg.position_count;
               pslot_in  = '0;
               ppen_in   = '0;
               nslot_in  = '0;
               npen_in   = '0;
               ptr_in    = {1'b0, anchor_sel} - PTR_W'(1);
               state_in  = (anchor_sel == '0) ? S_DONE : S_DOWN;
            end
         end
         S_DOWN: begin
            if (scan_valid) begin
               pslot_in = ptr_ff[POS_W-1:0];
               state_in = S_PCALC;
            end else if (ptr_ff == '0) begin
               ptr_in   = {1'b0, anchor_ff} + PTR_W'(1);
               state_in = S_UP;
            end else begin
               ptr_in = ptr_ff - PTR_W'(1);
            end
         end
         S_PCALC: begin
            // first - other
            if (!cov_ff[pslot_ff] && alu_pos) begin
               ppen_in = alu_res[POS_W-1:0];
            end
            ptr_in   = {1'b0, anchor_ff} + PTR_W'(1);
            state_in = S_UP;
         end
         S_UP: begin
            if (ptr_ff >= limit_ff) begin
               state_in = S_DONE;
            end else if (scan_valid) begin
               nslot_in = ptr_ff[POS_W-1:0];
               state_in = S_NCALC;
            end else begin
               ptr_in = ptr_ff + PTR_W'(1);
            end
         end
         S_NCALC: begin
            // other - last
            alu_a = other_ff;
            alu_b = span_rd[POS_W-1:0];
            if (!cov_ff[ptr_ff[POS_W-1:0]] && alu_pos) begin
               npen_in = alu_res[POS_W-1:0];
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            alu_a   = ppen_ff;
            alu_b   = npen_ff;
            alu_sub = 1'b0;
            rsp_in.prev_slot        = pslot_ff;
            rsp_in.prev_penalty     = ppen_ff;
            rsp_in.next_slot        = nslot_ff;
            rsp_in.next_penalty     = npen_ff;
            rsp_in.total_distortion = alu_res[POS_W:0];
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      anchor_ff <= anchor_in;
      other_ff  <= other_in;
      cov_ff    <= cov_in;
      limit_ff  <= limit_in;
      pslot_ff  <= pslot_in;
      ppen_ff   <= ppen_in;
      nslot_ff  <= nslot_in;
      npen_ff   <= npen_in;
      rsp_ff    <= rsp_in;
   end

   assign scan_ptr  = ptr_ff;
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[tb/nearest_anchor_distortion_test.sv]
`timescale 1ns / 100ps

// Checks the best-link span table: load beats fill the table, query beats
// scan it for the nearest valid entry on each side of the anchor and charge
// the distortion of the queried link. A local copy of the table and of the two
// registers predicts every query result; a checker compares each strobed
// result with the oldest prediction, field by field.
module nearest_anchor_distortion_test;
   import nad_pkg::*;

   localparam int TABLE_DEPTH   = 64;
   localparam int SETTLE_CYCLES = 80;        // longest query scan plus margin
   localparam int CYCLE_LIMIT   = 1_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_payload = '0;
   logic        rsp_valid;
   rsp_type     rsp_payload;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   nearest_anchor_distortion dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow of the block: span table and the two registers
   // ---------------------------------------------------------------------
   logic [TABLE_DEPTH-1:0] span_valid = '0;
   logic [POS_W-1:0]       span_first_tab [TABLE_DEPTH];
   logic [POS_W-1:0]       span_last_tab  [TABLE_DEPTH];
   logic                   cfg_parsing_source = 1'b1;
   logic [PTR_W-1:0]       cfg_position_count = 7'd64;

   rsp_type pending_distortions [$];   // predicted results, oldest first
   int      mismatches  = 0;
   int      cycle_count = 0;

   // Nearest valid entry below the anchor and nearest valid entry above it
   // (below the clamped position count), none for anchor zero. An entry whose
   // slot is covered is still reported, but charges nothing.
   function automatic rsp_type predict_distortion(req_type q);
      rsp_type    r;
      int         anchor;
      int         other;
      int         lim;
      int         p;
      r      = '0;
      anchor = int'(cfg_parsing_source ? q.src_pos : q.trg_pos);
      other  = int'(cfg_parsing_source ? q.trg_pos : q.src_pos);
      lim    = (int'(cfg_position_count) > TABLE_DEPTH) ? TABLE_DEPTH
                                                        : int'(cfg_position_count);
      if (anchor > 0) begin
         p = anchor - 1;
         while (p >= 0 && !span_valid[p[POS_W-1:0]])
            p--;
         if (p >= 0) begin
            r.prev_slot = POS_W'(p);
            if (!q.coverage[p[POS_W-1:0]] && other < int'(span_first_tab[p[POS_W-1:0]]))
               r.prev_penalty = POS_W'(int'(span_first_tab[p[POS_W-1:0]]) - other);
         end
         p = anchor + 1;
         while (p < lim && !span_valid[p[POS_W-1:0]])
            p++;
         if (p < lim) begin
            r.next_slot = POS_W'(p);
            if (!q.coverage[p[POS_W-1:0]] && other > int'(span_last_tab[p[POS_W-1:0]]))
               r.next_penalty = POS_W'(other - int'(span_last_tab[p[POS_W-1:0]]));
         end
      end
      r.total_distortion = {1'b0, r.prev_penalty} + {1'b0, r.next_penalty};
      return r;
   endfunction

   // Apply one accepted beat to the shadow: loads write the table, queries
   // queue up their predicted result.
   task automatic record_beat(input req_type q);
      if (q.kind == KIND_LOAD) begin
         span_valid[q.slot]     = q.entry_valid;
         span_first_tab[q.slot] = q.span_first;
         span_last_tab[q.slot]  = q.span_last;
      end else begin
         pending_distortions.insert(pending_distortions.size(), predict_distortion(q));
      end
   endtask

   function automatic req_type make_load(int slot, bit valid, int first, int last);
      req_type q;
      q             = '0;
      q.kind        = KIND_LOAD;
      q.slot        = POS_W'(slot);
      q.entry_valid = valid;
      q.span_first  = POS_W'(first);
      q.span_last   = POS_W'(last);
      return q;
   endfunction

   function automatic req_type make_query(int src, int trg, logic [63:0] cov);
      req_type q;
      q          = '0;
      q.kind     = KIND_QUERY;
      q.src_pos  = POS_W'(src);
      q.trg_pos  = POS_W'(trg);
      q.coverage = cov;
      return q;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("[%0d] mismatch %s: expected %0d, got %0d", cycle_count, what, want, got);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------
   // Request side. start is left high after a beat; the caller lowers it
   // only when it idles, so start never sees two assignments in one step.
   // ---------------------------------------------------------------------
   task automatic send_beat(input req_type q);
      start       <= 1'b1;
      req_payload <= q;
      do @(posedge clock); while (busy);
      record_beat(q);
   endtask

   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clock);
   endtask

   // Wait for every predicted result, then for a settling margin.
   task automatic wait_quiet();
      start <= 1'b0;
      while (pending_distortions.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Configuration port: setup phase, access phase, then idle
   // ---------------------------------------------------------------------
   task automatic csr_write(input logic idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_PARSING_SOURCE)
         cfg_parsing_source = value[0];
      else
         cfg_position_count = value[PTR_W-1:0];
      @(posedge clock);
   endtask

   task automatic csr_check(input logic idx);
      int want;
      want    = (idx == REG_PARSING_SOURCE) ? int'(cfg_parsing_source)
                                            : int'(cfg_position_count);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (idx == REG_PARSING_SOURCE) begin
         if (prdata[0] !== want[0])
            report_mismatch("parsing_source readback", want, int'(prdata[0]));
      end else if (prdata[PTR_W-1:0] !== want[PTR_W-1:0]) begin
         report_mismatch("position_count readback", want, int'(prdata[PTR_W-1:0]));
      end
      @(posedge clock);
   endtask

   task automatic set_config(input bit parsing_source, input int position_count);
      wait_quiet();
      csr_write(REG_PARSING_SOURCE, 32'(parsing_source));
      csr_write(REG_POSITION_COUNT, 32'(position_count));
      csr_check(REG_PARSING_SOURCE);
      csr_check(REG_POSITION_COUNT);
   endtask

   // ---------------------------------------------------------------------
   // Result checker: every strobe must match the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_distortions.size() == 0) begin
            $display("[%0d] result beat with nothing expected", cycle_count);
            mismatches++;
         end else begin
            want = pending_distortions.pop_front();
            if (rsp_payload.prev_slot !== want.prev_slot)
               report_mismatch("prev_slot", int'(want.prev_slot),
                               int'(rsp_payload.prev_slot));
            if (rsp_payload.prev_penalty !== want.prev_penalty)
               report_mismatch("prev_penalty", int'(want.prev_penalty),
                               int'(rsp_payload.prev_penalty));
            if (rsp_payload.next_slot !== want.next_slot)
               report_mismatch("next_slot", int'(want.next_slot),
                               int'(rsp_payload.next_slot));
            if (rsp_payload.next_penalty !== want.next_penalty)
               report_mismatch("next_penalty", int'(want.next_penalty),
                               int'(rsp_payload.next_penalty));
            if (rsp_payload.total_distortion !== want.total_distortion)
               report_mismatch("total_distortion", int'(want.total_distortion),
                               int'(rsp_payload.total_distortion));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("nearest_anchor_distortion_test NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Registers come out of reset as source-anchored, full count.
   task automatic test_register_defaults();
      csr_check(REG_PARSING_SOURCE);
      csr_check(REG_POSITION_COUNT);
   endtask

   // Searches under the reset configuration.
   task automatic test_search_cases();
      send_beat(make_query(5, 9, '0));                // empty table: nothing found
      send_beat(make_load(0, 1'b1, 63, 0));
      send_beat(make_load(63, 1'b1, 10, 2));
      send_beat(make_load(20, 1'b1, 30, 25));
      send_beat(make_query(0, 40, '0));               // anchor zero: no search
      send_beat(make_query(10, 5, '0));               // prev charges, next does not
      send_beat(make_query(10, 50, '0));              // both sides charge
      send_beat(make_query(10, 50, '1));              // both found, both covered
      send_beat(make_query(10, 50, 64'h1));           // only the prior entry covered
      send_beat(make_query(63, 63, '0));              // top anchor: upward scan empty
      send_beat(make_query(62, 63, '0));              // next is the top slot
      send_beat(make_query(1, 0, '0));                // largest prior charge
      send_beat(make_load(20, 1'b0, 0, 63));          // retire the middle entry
      send_beat(make_query(10, 50, '0));              // upward scan runs to the top
   endtask

   // Count clamping and the target-anchored direction.
   task automatic test_count_and_direction();
      set_config(1'b1, 127);                          // above table depth: clamped
      send_beat(make_query(62, 63, '0));
      set_config(1'b1, 0);                            // upward scan never runs
      send_beat(make_query(62, 63, '0));
      set_config(1'b1, 63);                           // top slot just out of reach
      send_beat(make_query(62, 63, '0));
      set_config(1'b0, 64);                           // target is the anchor
      send_beat(make_query(50, 10, '0));
      send_beat(make_query(40, 0, '0));               // target anchor zero
      send_beat(make_query(0, 62, 64'h8000_0000_0000_0000));
   endtask

   function automatic logic [63:0] random_coverage();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         2:       return {$urandom, $urandom};
         default: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      endcase
   endfunction

   // One configuration, a stream of loads and queries. valid_pct sets how
   // dense the table gets, which decides how far each scan walks.
   task automatic run_phase(input bit parsing_source, input int position_count,
                            input int valid_pct, input int beats, input bit idling);
      req_type q;
      set_config(parsing_source, position_count);
      for (int i = 0; i < beats; i++) begin
         if ($urandom_range(0, 99) < 35)
            q = make_load($urandom_range(0, 63), $urandom_range(0, 99) < valid_pct,
                          $urandom_range(0, 63), $urandom_range(0, 63));
         else
            q = make_query($urandom_range(0, 63), $urandom_range(0, 63), random_coverage());
         send_beat(q);
         if (idling && $urandom_range(0, 3) == 0)
            idle_burst();
      end
   endtask

   task automatic test_random_traffic();
      run_phase(1'b1, 64, 70, 200, 1'b1);
      run_phase(1'b0, 64, 30, 200, 1'b1);
      run_phase(1'b1, 127, 85, 150, 1'b1);
      run_phase(1'b0, 0, 60, 100, 1'b1);
      run_phase(1'b1, 1, 60, 100, 1'b1);
      run_phase(1'b0, $urandom_range(2, 63), 50, 200, 1'b1);
      run_phase(1'b1, 64, 60, 200, 1'b0);              // back to back, no idling
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_defaults();
      test_search_cases();
      test_count_and_direction();
      test_random_traffic();
      wait_quiet();
      if (mismatches == 0)
         $display("nearest_anchor_distortion_test OK");
      else
         $display("nearest_anchor_distortion_test NOT OK");
      $finish;
   end

endmodule
